FILE: hw/rtl/address_range_registry_macros.svh
// Assertion macros for the address range registry.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ADDRESS_RANGE_REGISTRY_MACROS_SVH
`define ADDRESS_RANGE_REGISTRY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ARA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("address_range_registry: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ARA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("address_range_registry: next-cycle check failed");

`endif

FILE: hw/rtl/ara_pkg.sv
// Shared types and constants of the address range registry.
// No dependencies; used by ara_cell and address_range_registry.
`default_nettype none

package ara_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int ADDR_BITS_DEF   = 48;
  localparam int OWNER_BITS_DEF  = 16;
  localparam int LEN_BITS        = 32;

  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_LOOKUP   = 2'd2,
    KIND_UNUSED   = 2'd3
  } ara_kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_OVERLAP     = 3'd2,
    ST_FULL        = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_OWNER_LIMIT = 3'd5
  } ara_status_t;

  // Write-back command broadcast to all cells after a scan.
  typedef enum logic [1:0] {
    WB_NONE       = 2'd0,
    WB_ADD_OWNER  = 2'd1,
    WB_DROP_OWNER = 2'd2,
    WB_INSERT     = 2'd3
  } ara_wb_t;

  // Summary of the slots scanned so far, passed from cell to cell.
  typedef struct packed {
    logic                hit;
    logic                match;
    logic                at_limit;
    logic                overlap;
    logic                free_seen;
    logic                found;
    logic [LEN_BITS-1:0] remain;
    logic                little_endian;
  } ara_acc_t;

endpackage

`default_nettype wire

FILE: hw/rtl/address_range_registry.sv
// Top level of the address range registry: request capture, cell chain, decision.
// Depends on ara_pkg, ara_cell and address_range_registry_macros.svh.
//
// Usage:
//   A request (in_kind, in_address, in_length, in_little_endian) is taken at a
//   rising edge where start is high and busy is low. Kinds: register a range,
//   release a range by its base, look up an address. One result per request.
//   The request walks a row of TABLE_SLOTS cells, one cell per cycle; each cell
//   owns one table slot and folds its compare results into a summary handed to
//   the next cell. After the last cell the outcome is decided and the table
//   is written back in the same cycle.
//   out_valid is high for one cycle, after the request has passed launch_r,
//   the token register of every cell and out_valid_r. busy drops with the
//   result, so a new request is taken only once the last one has its result;
//   the length of the cell row sets how long each request takes.
//   The result is shown for exactly one cycle; the receiver cannot stall it.
//   Reset (rst_n low, synchronous) empties the table and drops any request
//   in flight; no result is produced for it.
`default_nettype none
`include "address_range_registry_macros.svh"

module address_range_registry #(
  parameter int TABLE_SLOTS = ara_pkg::TABLE_SLOTS_DEF,
  parameter int ADDR_BITS   = ara_pkg::ADDR_BITS_DEF,
  parameter int OWNER_BITS  = ara_pkg::OWNER_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [ADDR_BITS-1:0]         in_address,
  input  wire logic [ara_pkg::LEN_BITS-1:0] in_length,
  input  wire logic                         in_little_endian,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [ara_pkg::LEN_BITS-1:0]      out_remaining_bytes,
  output logic                              out_range_little_endian
);

  localparam int EW = ((ADDR_BITS > ara_pkg::LEN_BITS) ? ADDR_BITS : ara_pkg::LEN_BITS) + 1;

  logic                         busy_r;
  logic                         busy_nxt;
  logic                         launch_r;
  logic                         accept;
  ara_pkg::ara_kind_t           req_kind_r;
  logic [ADDR_BITS-1:0]         req_addr_r;
  logic [ara_pkg::LEN_BITS-1:0] req_len_r;
  logic                         req_le_r;
  logic [EW-1:0]                req_end;
  logic                         bad_extent;

  logic [TABLE_SLOTS:0]         tok_w;
  ara_pkg::ara_acc_t            acc_w [TABLE_SLOTS+1];
  ara_pkg::ara_acc_t            acc_last;
  logic                         tok_last;
  ara_pkg::ara_wb_t             wb_cmd;
  ara_pkg::ara_wb_t             wb_nxt;

  logic                         out_valid_r;
  ara_pkg::ara_status_t         status_r;
  ara_pkg::ara_status_t         status_nxt;
  logic [ara_pkg::LEN_BITS-1:0] remain_r;
  logic [ara_pkg::LEN_BITS-1:0] remain_nxt;
  logic                         rle_r;
  logic                         rle_nxt;

  assign accept = start && !busy_r;

  always_comb begin
    busy_nxt = busy_r;
    if (accept) busy_nxt = 1'b1;
    else if (tok_last) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      launch_r    <= accept;
      out_valid_r <= tok_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind_r <= ara_pkg::ara_kind_t'(in_kind);
      req_addr_r <= in_address;
      req_len_r  <= in_length;
      req_le_r   <= in_little_endian;
    end
  end

  // scan chain
  assign tok_w[0] = launch_r;
  assign acc_w[0] = '0;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    ara_cell #(
      .ADDR_BITS  (ADDR_BITS),
      .OWNER_BITS (OWNER_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req_addr (req_addr_r),
      .req_len  (req_len_r),
      .req_le   (req_le_r),
      .tok_i    (tok_w[i]),
      .acc_i    (acc_w[i]),
      .tok_o    (tok_w[i+1]),
      .acc_o    (acc_w[i+1]),
      .wb_cmd   (wb_cmd)
    );
  end

  assign tok_last = tok_w[TABLE_SLOTS];
  assign acc_last = acc_w[TABLE_SLOTS];

  assign req_end    = EW'(req_addr_r) + EW'(req_len_r);
  assign bad_extent = (req_addr_r == '0) || (req_len_r == '0) || ((req_end >> ADDR_BITS) != '0);

  always_comb begin
    status_nxt = ara_pkg::ST_OK;
    remain_nxt = '0;
    rle_nxt    = 1'b0;
    wb_nxt     = ara_pkg::WB_NONE;
    case (req_kind_r)
      ara_pkg::KIND_REGISTER: begin
        if (bad_extent) begin
          status_nxt = ara_pkg::ST_INVALID;
        end else if (acc_last.match) begin
          if (acc_last.at_limit) status_nxt = ara_pkg::ST_OWNER_LIMIT;
          else wb_nxt = ara_pkg::WB_ADD_OWNER;
        end else if (acc_last.overlap) begin
          status_nxt = ara_pkg::ST_OVERLAP;
        end else if (!acc_last.free_seen) begin
          status_nxt = ara_pkg::ST_FULL;
        end else begin
          wb_nxt = ara_pkg::WB_INSERT;
        end
      end
      ara_pkg::KIND_RELEASE: begin
        if (acc_last.hit) wb_nxt = ara_pkg::WB_DROP_OWNER;
        else status_nxt = ara_pkg::ST_NOT_FOUND;
      end
      ara_pkg::KIND_LOOKUP: begin
        if (acc_last.found) begin
          remain_nxt = acc_last.remain;
          rle_nxt    = acc_last.little_endian;
        end else begin
          status_nxt = ara_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = ara_pkg::ST_INVALID;
      end
    endcase
  end

  // write back only in the decision cycle
  assign wb_cmd = tok_last ? wb_nxt : ara_pkg::WB_NONE;

  always_ff @(posedge clk) begin
    if (tok_last) begin
      status_r <= status_nxt;
      remain_r <= remain_nxt;
      rle_r    <= rle_nxt;
    end
  end

  assign busy                    = busy_r;
  assign out_valid               = out_valid_r;
  assign out_status              = status_r;
  assign out_remaining_bytes     = remain_r;
  assign out_range_little_endian = rle_r;

  `ARA_ASSERT_IMP(a_single_token, 1'b1, $onehot0(tok_w))
  `ARA_ASSERT_IMP(a_idle_chain_empty, !busy_r, tok_w == '0)
  `ARA_ASSERT_NXT(a_result_after_scan, tok_last, out_valid_r && !busy_r)
  `ARA_ASSERT_IMP(a_no_result_while_busy, out_valid_r, !busy_r)

endmodule

`default_nettype wire

FILE: hw/rtl/ara_cell.sv
// One slot of the range table plus one stage of the scan chain.
// Depends on ara_pkg.
`default_nettype none

module ara_cell #(
  parameter int ADDR_BITS  = ara_pkg::ADDR_BITS_DEF,
  parameter int OWNER_BITS = ara_pkg::OWNER_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [ADDR_BITS-1:0]         req_addr,
  input  wire logic [ara_pkg::LEN_BITS-1:0] req_len,
  input  wire logic                         req_le,
  input  wire logic                         tok_i,
  input  wire ara_pkg::ara_acc_t            acc_i,
  output logic                              tok_o,
  output ara_pkg::ara_acc_t                 acc_o,
  input  wire ara_pkg::ara_wb_t             wb_cmd
);

  localparam int EW = ((ADDR_BITS > ara_pkg::LEN_BITS) ? ADDR_BITS : ara_pkg::LEN_BITS) + 1;

  logic                         valid_r;
  logic [ADDR_BITS-1:0]         base_r;
  logic [ara_pkg::LEN_BITS-1:0] size_r;
  logic                         endian_r;
  logic [OWNER_BITS-1:0]        owners_r;
  logic                         sel_hit_r;
  logic                         sel_free_r;
  logic                         tok_r;
  ara_pkg::ara_acc_t            acc_r;
  ara_pkg::ara_acc_t            acc_nxt;

  logic [EW-1:0]                req_end;
  logic [EW-1:0]                slot_end;
  logic [ADDR_BITS-1:0]         off;
  logic [EW-1:0]                off_ext;
  logic                         hit_l;
  logic                         match_l;
  logic                         overlap_l;
  logic                         in_l;

  assign req_end  = EW'(req_addr) + EW'(req_len);
  assign slot_end = EW'(base_r) + EW'(size_r);
  assign off      = req_addr - base_r;
  assign off_ext  = EW'(off);

  assign hit_l     = valid_r && (base_r == req_addr);
  assign match_l   = hit_l && (size_r == req_len) && (endian_r == req_le);
  assign overlap_l = valid_r && (EW'(base_r) < req_end) && (EW'(req_addr) < slot_end);
  assign in_l      = valid_r && (base_r <= req_addr) && (off_ext < EW'(size_r));

  always_comb begin
    acc_nxt           = acc_i;
    acc_nxt.hit       = acc_i.hit | hit_l;
    acc_nxt.overlap   = acc_i.overlap | overlap_l;
    acc_nxt.free_seen = acc_i.free_seen | !valid_r;
    if (match_l) begin
      acc_nxt.match    = 1'b1;
      acc_nxt.at_limit = (owners_r == '1);
    end
    // keep the first containing range
    if (in_l && !acc_i.found) begin
      acc_nxt.found         = 1'b1;
      acc_nxt.remain        = size_r - off_ext[ara_pkg::LEN_BITS-1:0];
      acc_nxt.little_endian = endian_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_i) begin
      acc_r      <= acc_nxt;
      sel_hit_r  <= hit_l;
      sel_free_r <= !valid_r && !acc_i.free_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (wb_cmd)
        ara_pkg::WB_INSERT: begin
          if (sel_free_r) valid_r <= 1'b1;
        end
        ara_pkg::WB_DROP_OWNER: begin
          if (sel_hit_r && (owners_r == OWNER_BITS'(1))) valid_r <= 1'b0;
        end
        default: begin
          valid_r <= valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (wb_cmd)
      ara_pkg::WB_INSERT: begin
        if (sel_free_r) begin
          base_r   <= req_addr;
          size_r   <= req_len;
          endian_r <= req_le;
          owners_r <= OWNER_BITS'(1);
        end
      end
      ara_pkg::WB_ADD_OWNER: begin
        if (sel_hit_r) owners_r <= owners_r + OWNER_BITS'(1);
      end
      ara_pkg::WB_DROP_OWNER: begin
        if (sel_hit_r) owners_r <= owners_r - OWNER_BITS'(1);
      end
      default: begin
        owners_r <= owners_r;
      end
    endcase
  end

  assign tok_o = tok_r;
  assign acc_o = acc_r;

endmodule

`default_nettype wire
